[hdl/salc_pkg.sv]
// Shared types and constants for the set-associative LRU cache tag model.
// No dependencies; used by the controller, datapath, top level and testbench.
package salc_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_WAYS_LOG2 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POLICY    = 2'd1;

	// replacement / prefetch policy codes
	localparam logic [1:0] POL_PLAIN          = 2'd0;
	localparam logic [1:0] POL_NO_STORE_ALLOC = 2'd1;
	localparam logic [1:0] POL_PF_ALWAYS      = 2'd2;
	localparam logic [1:0] POL_PF_MISS        = 2'd3;

	// lru rank storage
	localparam int RANK_W = 9;
	localparam logic [RANK_W-1:0] RANK_MAX = 9'd511;

	// next-line prefetch distance in bytes
	localparam int PF_STRIDE = 32;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_EVAL,
		ST_DECIDE,
		ST_UPD_RD,
		ST_UPD_WR,
		ST_POST
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic clr_wr;
		logic load;
		logic start_next;
		logic k_clr;
		logic k_inc;
		logic mem_rd;
		logic scan_eval;
		logic decide;
		logic upd_wr;
		logic finish;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic clr_last;
		logic way_last;
		logic need_update;
		logic need_prefetch;
		logic out_free;
	} sts_t;

endpackage

[hdl/salc_req_if.sv]
// Request channel: one load or store address per request.
// Depends on nothing.
interface salc_req_if;
	logic        valid;
	logic        ready;
	logic [31:0] address;
	logic        op;

	modport source (output valid, output address, output op, input ready);
	modport sink (input valid, input address, input op, output ready);
endinterface

[hdl/salc_rsp_if.sv]
// Response channel: hit flag with running hit and access counts.
// Depends on nothing.
interface salc_rsp_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic [31:0] hit_count;
	logic [31:0] access_count;

	modport source (output valid, output hit, output hit_count, output access_count,
		input ready);
	modport sink (input valid, input hit, input hit_count, input access_count,
		output ready);
endinterface

[hdl/salc_ctrl.sv]
// Sequencer for the cache tag model: clearing pass, way scan, lru update, prefetch.
// Depends on salc_pkg.
module salc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  salc_pkg::sts_t   sts,
	output salc_pkg::cmd_t   cmd
);

	salc_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= salc_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			salc_pkg::ST_CLEAR: begin
				if (sts.clr_last) state_d = salc_pkg::ST_IDLE;
			end
			salc_pkg::ST_IDLE: begin
				if (req_valid) state_d = salc_pkg::ST_SCAN_RD;
			end
			salc_pkg::ST_SCAN_RD: begin
				state_d = salc_pkg::ST_SCAN_EVAL;
			end
			salc_pkg::ST_SCAN_EVAL: begin
				state_d = sts.way_last ? salc_pkg::ST_DECIDE : salc_pkg::ST_SCAN_RD;
			end
			salc_pkg::ST_DECIDE: begin
				state_d = sts.need_update ? salc_pkg::ST_UPD_RD : salc_pkg::ST_POST;
			end
			salc_pkg::ST_UPD_RD: begin
				state_d = salc_pkg::ST_UPD_WR;
			end
			salc_pkg::ST_UPD_WR: begin
				state_d = sts.way_last ? salc_pkg::ST_POST : salc_pkg::ST_UPD_RD;
			end
			salc_pkg::ST_POST: begin
				if (sts.need_prefetch) state_d = salc_pkg::ST_SCAN_RD;
				else if (sts.out_free) state_d = salc_pkg::ST_IDLE;
			end
			default: state_d = salc_pkg::ST_CLEAR;
		endcase
	end

	// command outputs
	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			salc_pkg::ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				cmd.k_inc  = 1'b1;
			end
			salc_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
				cmd.k_clr = 1'b1;
			end
			salc_pkg::ST_SCAN_RD: begin
				cmd.mem_rd = 1'b1;
			end
			salc_pkg::ST_SCAN_EVAL: begin
				cmd.scan_eval = 1'b1;
				cmd.k_inc     = !sts.way_last;
				cmd.k_clr     = sts.way_last;
			end
			salc_pkg::ST_DECIDE: begin
				cmd.decide = 1'b1;
			end
			salc_pkg::ST_UPD_RD: begin
				cmd.mem_rd = 1'b1;
			end
			salc_pkg::ST_UPD_WR: begin
				cmd.upd_wr = 1'b1;
				cmd.k_inc  = !sts.way_last;
				cmd.k_clr  = sts.way_last;
			end
			salc_pkg::ST_POST: begin
				cmd.start_next = sts.need_prefetch;
				cmd.k_clr      = 1'b1;
				cmd.finish     = !sts.need_prefetch && sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

[hdl/salc_dp.sv]
// Datapath for the cache tag model: tag/rank memory, scan registers, counters.
// Depends on salc_pkg.
module salc_dp #(
	parameter int NUM_LINES  = 512,
	parameter int LINE_BYTES = 32,
	parameter int ADDR_BITS  = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [salc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [salc_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [31:0]                       in_address,
	input  logic                              in_op,
	input  salc_pkg::cmd_t                    cmd,
	output salc_pkg::sts_t                    sts,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              out_hit,
	output logic [31:0]                       out_hit_count,
	output logic [31:0]                       out_access_count
);

	localparam int LW   = $clog2(NUM_LINES);
	localparam int OFF  = $clog2(LINE_BYTES);
	localparam int TAGW = ADDR_BITS - OFF;
	localparam int WLW  = $clog2(LW + 1);
	localparam int RW   = salc_pkg::RANK_W;
	localparam int MW   = 1 + RW + TAGW;

	// configuration registers
	logic [3:0] ways_log2_q;
	logic [1:0] policy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ways_log2_q <= '0;
			policy_q    <= salc_pkg::POL_PLAIN;
		end else if (cfg_we) begin
			if (cfg_index == salc_pkg::REG_WAYS_LOG2) ways_log2_q <= cfg_data;
			if (cfg_index == salc_pkg::REG_POLICY) policy_q <= cfg_data[1:0];
		end
	end

	// effective geometry, associativity clamped to fully associative
	logic [WLW-1:0] wl;
	logic [LW-1:0]  ways_m1;
	assign wl      = (int'(ways_log2_q) > LW) ? WLW'(LW) : WLW'(ways_log2_q);
	assign ways_m1 = LW'((LW+1)'(1) << wl) - LW'(1);

	// current access
	logic [ADDR_BITS-1:0] addr_q;
	logic                 op_q;
	logic                 phase_q;
	logic [LW-1:0]        k_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q <= ADDR_BITS'(in_address);
			op_q   <= in_op;
		end else if (cmd.start_next) begin
			addr_q <= addr_q + ADDR_BITS'(salc_pkg::PF_STRIDE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			k_q     <= '0;
		end else begin
			if (cmd.load) phase_q <= 1'b0;
			else if (cmd.start_next) phase_q <= 1'b1;
			if (cmd.k_clr) k_q <= '0;
			else if (cmd.k_inc) k_q <= k_q + LW'(1);
		end
	end

	// set index and tag split
	logic [TAGW-1:0] blk, tag;
	logic [LW-1:0]   line;
	assign blk  = addr_q[ADDR_BITS-1:OFF];
	assign tag  = blk >> (WLW'(LW) - wl);
	assign line = LW'(LW'(blk) << wl) | k_q;

	// tag, rank and valid memory
	logic [MW-1:0] mem [NUM_LINES];
	logic [MW-1:0] rd_q;
	logic [MW-1:0] wr_word;
	logic          rd_valid;
	logic [RW-1:0] rd_rank;
	logic [TAGW-1:0] rd_tag;
	assign {rd_valid, rd_rank, rd_tag} = rd_q;

	always_ff @(posedge clk) begin
		if (cmd.clr_wr) mem[k_q] <= '0;
		else if (cmd.upd_wr) mem[line] <= wr_word;
		if (cmd.mem_rd) rd_q <= mem[line];
	end

	// scan registers
	logic            hit_found_q, inv_found_q;
	logic [LW-1:0]   hit_way_q, inv_way_q, vic_way_q;
	logic [RW-1:0]   hit_rank_q, vic_rank_q;
	logic            match, first;
	assign match = rd_valid && (rd_tag == tag);
	assign first = (k_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.scan_eval) begin
			if (first || (!hit_found_q && match)) begin
				hit_found_q <= match;
				hit_way_q   <= k_q;
				hit_rank_q  <= rd_rank;
			end
			if (first || (!inv_found_q && !rd_valid)) begin
				inv_found_q <= !rd_valid;
				inv_way_q   <= k_q;
			end
			if (first || (rd_rank > vic_rank_q)) begin
				vic_way_q  <= k_q;
				vic_rank_q <= rd_rank;
			end
		end
	end

	// update target chosen after the scan
	logic          alloc;
	logic [LW-1:0] tgt_way_q;
	logic [RW-1:0] tgt_rank_q;
	logic          tgt_hit_q, tgt_sat_q, dem_hit_q;
	assign alloc = phase_q || (policy_q != salc_pkg::POL_NO_STORE_ALLOC) || !op_q;

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			tgt_hit_q  <= hit_found_q;
			tgt_sat_q  <= !hit_found_q && inv_found_q;
			tgt_way_q  <= hit_found_q ? hit_way_q : (inv_found_q ? inv_way_q : vic_way_q);
			tgt_rank_q <= hit_found_q ? hit_rank_q : vic_rank_q;
			if (!phase_q) dem_hit_q <= hit_found_q;
		end
	end

	// read-modify-write of one way during the lru update
	logic inc;
	assign inc = rd_valid && (tgt_sat_q ? (rd_rank < salc_pkg::RANK_MAX)
		: (rd_rank < tgt_rank_q));

	always_comb begin
		if (k_q == tgt_way_q) begin
			wr_word = {1'b1, RW'(0), tgt_hit_q ? rd_tag : tag};
		end else begin
			wr_word = {rd_valid, inc ? rd_rank + RW'(1) : rd_rank, rd_tag};
		end
	end

	// response register and counters
	logic        out_valid_q, out_hit_q;
	logic [31:0] hits_q, accs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			hits_q      <= '0;
			accs_q      <= '0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
				hits_q      <= hits_q + 32'(dem_hit_q);
				accs_q      <= accs_q + 32'd1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) out_hit_q <= dem_hit_q;
	end

	assign out_valid        = out_valid_q;
	assign out_hit          = out_hit_q;
	assign out_hit_count    = hits_q;
	assign out_access_count = accs_q;

	// status to the sequencer
	assign sts.clr_last      = (k_q == LW'(NUM_LINES - 1));
	assign sts.way_last      = (k_q == ways_m1);
	assign sts.need_update   = hit_found_q || alloc;
	assign sts.need_prefetch = !phase_q && ((policy_q == salc_pkg::POL_PF_ALWAYS)
		|| ((policy_q == salc_pkg::POL_PF_MISS) && !dem_hit_q));
	assign sts.out_free      = !out_valid_q || out_ready;

endmodule

[hdl/set_assoc_lru_cache_tag_model.sv]
// Set-associative cache tag model with true LRU replacement and next-line prefetch.
// Channel req carries an address and an op (0 load, 1 store); channel rsp returns
// hit, hit_count and access_count, one response per request, in order.
// Configuration: cfg_we with cfg_index 0 writes ways_log2, index 1 writes policy
// (0 plain, 1 no store allocate, 2 prefetch always, 3 prefetch on miss); write only
// while idle.
// After reset the block sweeps its line memory to invalidate it, with req.ready low.
// For each request the single memory port reads every way of the set
// (W = 2^ways_log2 ways, clamped to NUM_LINES) and then rewrites every way's rank;
// with a prefetch, the scan and rewrite repeat for the next line. A lookup that
// neither hits nor allocates skips the rewrite.
// The response is held in an output register; the next request is taken while it
// waits, and a new response waits for the old one to be taken when rsp is stalled.
// Depends on salc_pkg, salc_req_if, salc_rsp_if, salc_ctrl and salc_dp.
module set_assoc_lru_cache_tag_model #(
	parameter int NUM_LINES  = 512,
	parameter int LINE_BYTES = 32,
	parameter int ADDR_BITS  = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [salc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [salc_pkg::CFG_DATA_W-1:0] cfg_data,
	salc_req_if.sink                        req,
	salc_rsp_if.source                      rsp
);

	salc_pkg::cmd_t cmd;
	salc_pkg::sts_t sts;

	// sequencer
	salc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// memory, scan and counters
	salc_dp #(
		.NUM_LINES  (NUM_LINES),
		.LINE_BYTES (LINE_BYTES),
		.ADDR_BITS  (ADDR_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_address       (req.address),
		.in_op            (req.op),
		.cmd              (cmd),
		.sts              (sts),
		.out_valid        (rsp.valid),
		.out_ready        (rsp.ready),
		.out_hit          (rsp.hit),
		.out_hit_count    (rsp.hit_count),
		.out_access_count (rsp.access_count)
	);

endmodule

[hdl/salc_checker.sv]
// Port-level checks for the cache tag model, bound to the top level.
// Depends on set_assoc_lru_cache_tag_model and its interfaces.
module salc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        rsp_hit,
	input logic [31:0] rsp_access_count
);

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit)
		&& $stable(rsp_access_count))
		else $error("response changed while stalled");

	// a response following a taken one is a new access
	a_rsp_new: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready |=> !rsp_valid
		|| (rsp_access_count != $past(rsp_access_count)))
		else $error("response repeated");

	// no request taken in the first cycle of the invalidation sweep
	a_clear_busy: assert property (@(posedge clk)
		$rose(arst_n) |-> !req_ready)
		else $error("request taken during invalidation");

endmodule

bind set_assoc_lru_cache_tag_model salc_checker u_salc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_hit          (rsp.hit),
	.rsp_access_count (rsp.access_count)
);

[tb/set_assoc_lru_cache_tag_model_test.sv]
// Testbench for set_assoc_lru_cache_tag_model: a table of directed requests, then random
// address traces under several geometries and policies, checked against a tag/LRU predictor.
// Depends on salc_pkg, salc_req_if, salc_rsp_if and the block's RTL.
module set_assoc_lru_cache_tag_model_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  LINES    = 512;
	localparam int  WL_MAX   = 9;
	localparam int  BLK_SH   = 5;
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_STORE = 1'b1;

	typedef enum logic [0:0] {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t                        kind;
		logic [31:0]                      address;
		logic                             op;
		logic [salc_pkg::CFG_IDX_W-1:0]   reg_idx;
		logic [salc_pkg::CFG_DATA_W-1:0]  reg_val;
		bit                               typed;
		logic                             hit;
		logic [31:0]                      hits;
		logic [31:0]                      accesses;
	} row_t;

	typedef struct {
		logic        hit;
		logic [31:0] hits;
		logic [31:0] accesses;
	} outcome_t;

	typedef struct {
		int unsigned wl;
		logic [1:0]  pol;
		int          count;
		bit          pause;
	} phase_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [salc_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [salc_pkg::CFG_DATA_W-1:0] cfg_data;

	salc_req_if req ();
	salc_rsp_if rsp ();

	set_assoc_lru_cache_tag_model DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req.sink),
		.rsp       (rsp.source)
	);

	always #1 clk = ~clk;

	// predictor state
	bit [26:0]   tag_mem [LINES];
	bit          valid_mem [LINES];
	int unsigned rank_mem [LINES];
	bit [31:0]   hit_total;
	bit [31:0]   access_total;
	int unsigned cur_ways_log2;
	logic [1:0]  cur_policy;

	outcome_t pending_q[$];
	int       fail_count;
	bit       quiet;

	// move one way to most recent, aging the younger valid ways
	function automatic void promote_way(int base, int ways, int w);
		int unsigned r;
		r = rank_mem[base + w];
		for (int k = 0; k < ways; k++) begin
			if (k != w && valid_mem[base + k] && rank_mem[base + k] < r)
				rank_mem[base + k]++;
		end
		rank_mem[base + w] = 0;
	endfunction

	// one tag lookup with optional fill / LRU eviction
	function automatic bit cache_lookup(bit [31:0] a, bit alloc);
		int unsigned wl;
		int ways, sets, set_idx, base, victim;
		bit [26:0] blk, tg;
		wl = (cur_ways_log2 > WL_MAX) ? WL_MAX : cur_ways_log2;
		ways = 1 << wl;
		sets = LINES / ways;
		blk = 27'(a >> BLK_SH);
		set_idx = blk % sets;
		tg = 27'(blk / sets);
		base = set_idx * ways;
		for (int k = 0; k < ways; k++) begin
			if (valid_mem[base + k] && tag_mem[base + k] == tg) begin
				promote_way(base, ways, k);
				return 1'b1;
			end
		end
		if (!alloc)
			return 1'b0;
		// fill the first invalid way
		for (int k = 0; k < ways; k++) begin
			if (!valid_mem[base + k]) begin
				for (int j = 0; j < ways; j++) begin
					if (j != k && valid_mem[base + j] &&
						rank_mem[base + j] < salc_pkg::RANK_MAX)
						rank_mem[base + j]++;
				end
				valid_mem[base + k] = 1'b1;
				tag_mem[base + k] = tg;
				rank_mem[base + k] = 0;
				return 1'b0;
			end
		end
		// evict the oldest way, lowest way on a tie
		victim = 0;
		for (int k = 1; k < ways; k++) begin
			if (rank_mem[base + k] > rank_mem[base + victim])
				victim = k;
		end
		tag_mem[base + victim] = tg;
		promote_way(base, ways, victim);
		return 1'b0;
	endfunction

	// full effect of one accepted request
	function automatic outcome_t predict_access(bit [31:0] a, logic op);
		outcome_t o;
		bit h;
		bit [31:0] nxt;
		nxt = a + 32'(salc_pkg::PF_STRIDE);
		case (cur_policy)
			salc_pkg::POL_NO_STORE_ALLOC: begin
				h = cache_lookup(a, op != OP_STORE);
			end
			salc_pkg::POL_PF_ALWAYS: begin
				h = cache_lookup(a, 1'b1);
				void'(cache_lookup(nxt, 1'b1));
			end
			salc_pkg::POL_PF_MISS: begin
				h = cache_lookup(a, 1'b1);
				if (!h)
					void'(cache_lookup(nxt, 1'b1));
			end
			default: begin
				h = cache_lookup(a, 1'b1);
			end
		endcase
		if (h)
			hit_total++;
		access_total++;
		o.hit = h;
		o.hits = hit_total;
		o.accesses = access_total;
		return o;
	endfunction

	// drive one request and wait for it to be taken
	task automatic send_request(logic [31:0] a, logic op, bit typed, outcome_t typed_out);
		outcome_t o;
		req.valid <= 1'b1;
		req.address <= a;
		req.op <= op;
		do @(posedge clk); while (!req.ready);
		o = predict_access(a, op);
		pending_q.push_back(typed ? typed_out : o);
	endtask

	// random sender idle burst after a request
	task automatic maybe_idle();
		if (!quiet && $urandom_range(0, 5) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	// stop sending and let every response come back
	task automatic drain();
		req.valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic [salc_pkg::CFG_IDX_W-1:0] idx,
		logic [salc_pkg::CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == salc_pkg::REG_WAYS_LOG2)
			cur_ways_log2 = 32'(val);
		else if (idx == salc_pkg::REG_POLICY)
			cur_policy = val[1:0];
	endtask

	// response side: check on acceptance, random stall bursts
	initial begin : rsp_side
		int stall_left;
		outcome_t want;
		bit bad;
		stall_left = 0;
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready) begin
				if (pending_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("response with nothing pending: hit=%0b hits=%0d acc=%0d",
							rsp.hit, rsp.hit_count, rsp.access_count);
				end else begin
					want = pending_q.pop_front();
					bad = (rsp.hit !== want.hit) || (rsp.hit_count !== want.hits) ||
						(rsp.access_count !== want.accesses);
					if (bad) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: hit %0b/%0b hits %0d/%0d acc %0d/%0d (exp/got)",
								want.hit, rsp.hit, want.hits, rsp.hit_count,
								want.accesses, rsp.access_count);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 10) - 1;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// hard limit on run time
	initial begin
		#10ms;
		$display("Some tests failed");
		$finish;
	end

	// stimulus
	initial begin : stim
		row_t rows[$];
		phase_t phases[$];
		logic [31:0] hot_hi[8];
		logic [31:0] a;
		outcome_t t;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req.valid = 1'b0;
		req.address = '0;
		req.op = OP_LOAD;
		fail_count = 0;
		quiet = 1'b0;
		hit_total = '0;
		access_total = '0;
		cur_ways_log2 = 0;
		cur_policy = salc_pkg::POL_PLAIN;
		foreach (valid_mem[i]) begin
			valid_mem[i] = 1'b0;
			rank_mem[i] = 0;
		end

		// directed table; typed rows are plain read-offs after reset
		rows = '{
			'{ROW_REQ, 32'h0000_0000, OP_LOAD,  '0, '0, 1, 1'b0, 32'd0, 32'd1},
			'{ROW_REQ, 32'h0000_0000, OP_LOAD,  '0, '0, 1, 1'b1, 32'd1, 32'd2},
			'{ROW_REQ, 32'hFFFF_FFFF, OP_STORE, '0, '0, 1, 1'b0, 32'd1, 32'd3},
			'{ROW_REQ, 32'hFFFF_FFE0, OP_STORE, '0, '0, 1, 1'b1, 32'd2, 32'd4},
			'{ROW_REQ, 32'h0000_001F, OP_LOAD,  '0, '0, 1, 1'b1, 32'd3, 32'd5},
			'{ROW_REQ, 32'h0000_4000, OP_LOAD,  '0, '0, 0, 1'b0, 32'd0, 32'd0},
			'{ROW_REQ, 32'h0000_0000, OP_LOAD,  '0, '0, 0, 1'b0, 32'd0, 32'd0},
			'{ROW_CFG, '0, OP_LOAD, salc_pkg::REG_POLICY,
				salc_pkg::CFG_DATA_W'(salc_pkg::POL_NO_STORE_ALLOC), 0, 0, 0, 0},
			'{ROW_REQ, 32'h0000_8000, OP_STORE, '0, '0, 0, 1'b0, 32'd0, 32'd0},
			'{ROW_REQ, 32'h0000_8000, OP_LOAD,  '0, '0, 0, 1'b0, 32'd0, 32'd0},
			'{ROW_REQ, 32'h0000_8000, OP_STORE, '0, '0, 0, 1'b0, 32'd0, 32'd0},
			'{ROW_CFG, '0, OP_LOAD, salc_pkg::REG_WAYS_LOG2, 4'd2, 0, 0, 0, 0},
			'{ROW_REQ, 32'h0000_0020, OP_LOAD,  '0, '0, 0, 1'b0, 32'd0, 32'd0},
			'{ROW_REQ, 32'h0000_1020, OP_STORE, '0, '0, 0, 1'b0, 32'd0, 32'd0},
			'{ROW_CFG, '0, OP_LOAD, salc_pkg::REG_POLICY,
				salc_pkg::CFG_DATA_W'(salc_pkg::POL_PF_ALWAYS), 0, 0, 0, 0},
			'{ROW_REQ, 32'hFFFF_FFF0, OP_LOAD,  '0, '0, 0, 1'b0, 32'd0, 32'd0},
			'{ROW_REQ, 32'h0000_0010, OP_LOAD,  '0, '0, 0, 1'b0, 32'd0, 32'd0},
			'{ROW_CFG, '0, OP_LOAD, salc_pkg::REG_POLICY,
				salc_pkg::CFG_DATA_W'(salc_pkg::POL_PF_MISS), 0, 0, 0, 0},
			'{ROW_REQ, 32'h1234_0000, OP_LOAD,  '0, '0, 0, 1'b0, 32'd0, 32'd0},
			'{ROW_REQ, 32'h1234_0020, OP_LOAD,  '0, '0, 0, 1'b0, 32'd0, 32'd0},
			'{ROW_REQ, 32'h1234_0000, OP_STORE, '0, '0, 0, 1'b0, 32'd0, 32'd0},
			'{ROW_CFG, '0, OP_LOAD, salc_pkg::REG_WAYS_LOG2, 4'd9, 0, 0, 0, 0},
			'{ROW_REQ, 32'hAAAA_AAAA, OP_LOAD,  '0, '0, 0, 1'b0, 32'd0, 32'd0},
			'{ROW_REQ, 32'h5555_5555, OP_STORE, '0, '0, 0, 1'b0, 32'd0, 32'd0},
			'{ROW_REQ, 32'hAAAA_AAA0, OP_LOAD,  '0, '0, 0, 1'b0, 32'd0, 32'd0}
		};

		// random phases; large geometries get few requests, last one runs without idling
		phases = '{
			'{0, salc_pkg::POL_PLAIN,          70, 0},
			'{2, salc_pkg::POL_NO_STORE_ALLOC, 70, 1},
			'{1, salc_pkg::POL_PF_ALWAYS,      60, 0},
			'{3, salc_pkg::POL_PF_MISS,        60, 0},
			'{4, salc_pkg::POL_PLAIN,          60, 0},
			'{9, salc_pkg::POL_PF_ALWAYS,      10, 0},
			'{15, salc_pkg::POL_PLAIN,         10, 0},
			'{6, salc_pkg::POL_NO_STORE_ALLOC, 50, 0},
			'{0, salc_pkg::POL_PF_MISS,        60, 0}
		};

		// reset, then the post-reset clearing sweep is covered by waiting on ready
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_CFG) begin
				drain();
				write_reg(rows[i].reg_idx, rows[i].reg_val);
			end else begin
				t.hit = rows[i].hit;
				t.hits = rows[i].hits;
				t.accesses = rows[i].accesses;
				send_request(rows[i].address, rows[i].op, rows[i].typed, t);
				maybe_idle();
			end
		end

		foreach (phases[p]) begin
			drain();
			write_reg(salc_pkg::REG_WAYS_LOG2, salc_pkg::CFG_DATA_W'(phases[p].wl));
			write_reg(salc_pkg::REG_POLICY, salc_pkg::CFG_DATA_W'(phases[p].pol));
			if (p == phases.size() - 1)
				quiet = 1'b1;
			// a few hot tags over a few sets keep hits and evictions frequent
			foreach (hot_hi[h])
				hot_hi[h] = $urandom() & 32'hFFFF_C000;
			for (int n = 0; n < phases[p].count; n++) begin
				if ($urandom_range(0, 9) < 8)
					a = hot_hi[$urandom_range(0, 7)] | (32'($urandom_range(0, 15)) << BLK_SH) |
						32'($urandom_range(0, 31));
				else
					a = $urandom();
				send_request(a, 1'($urandom_range(0, 1)), 1'b0, t);
				if (phases[p].pause && n == phases[p].count / 2)
					drain();
				maybe_idle();
			end
		end

		drain();
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
